### hdl/imh_pkg.sv
// Shared types and codes for the indexed min-heap.
package imh_pkg;

  // Fixed sizes: heap capacity and grid side
  localparam int CAPACITY  = 4096;
  localparam int GRID_SIDE = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DECKEY = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DK_RD,
    S_DK_WAIT,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_DEL_RD0,
    S_DEL_WAIT0,
    S_DEL_LAST,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_LK_RD,
    S_LK_WAIT,
    S_PLACE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;     // write one table entry to -1 and advance the sweep
    logic latch_in;     // capture the transaction fields
    logic rd_node_pos;  // read node at current position
    logic rd_root;      // read root node (for table clear on delete)
    logic rd_last;      // read last node
    logic rd_parent;    // read parent node
    logic rd_children;  // read both children
    logic rd_tbl;       // read table at the input cell
    logic load_cur;     // take read node as the moving node (decrease key)
    logic load_last;    // take read node as the moving node (delete)
    logic clr_root_tbl; // write -1 to the table entry of the read root
    logic cnt_inc;
    logic cnt_dec;
    logic init_ins;     // position := count
    logic init_root;    // position := 0
    logic move_up;      // parent -> position, position := parent
    logic move_down;    // picked child -> position, position := child
    logic place;        // write moving node at position
    logic set_pos;      // result position := current position
    logic set_tbl;      // result position := table read
    logic set_status;
    status_t status;
    logic done;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic    clr_last;
    op_t     op;
    logic    in_grid;
    logic    full;
    logic    empty;
    logic    idx_bad;
    logic    at_root;
    logic    parent_gt;
    logic    child_lt;
    logic    one_left; // count is exactly one
  } sts_t;

endpackage

### hdl/imh_ctrl.sv
// Controller state machine for the indexed min-heap.
module imh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  imh_pkg::sts_t  sts,
  output imh_pkg::cmd_t  cmd
);

  imh_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= imh_pkg::S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != imh_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status = imh_pkg::ST_OK;
    unique case (state_r)
      imh_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = imh_pkg::S_IDLE;
      end
      imh_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_nxt = imh_pkg::S_DECODE;
        end
      end
      imh_pkg::S_DECODE: begin
        cmd.set_status = 1'b1;
        state_nxt = imh_pkg::S_DONE;
        unique case (sts.op)
          imh_pkg::OP_INSERT: begin
            if (!sts.in_grid) cmd.status = imh_pkg::ST_RANGE;
            else if (sts.full) cmd.status = imh_pkg::ST_FULL;
            else begin
              cmd.init_ins = 1'b1;
              cmd.cnt_inc = 1'b1;
              state_nxt = imh_pkg::S_UP_RD;
            end
          end
          imh_pkg::OP_DECKEY: begin
            if (sts.idx_bad) cmd.status = imh_pkg::ST_RANGE;
            else state_nxt = imh_pkg::S_DK_RD;
          end
          imh_pkg::OP_DELETE: begin
            if (sts.empty) cmd.status = imh_pkg::ST_EMPTY;
            else state_nxt = imh_pkg::S_DEL_RD0;
          end
          imh_pkg::OP_LOOKUP: begin
            if (!sts.in_grid) cmd.status = imh_pkg::ST_RANGE;
            else state_nxt = imh_pkg::S_LK_RD;
          end
          default: state_nxt = imh_pkg::S_DONE;
        endcase
      end
      imh_pkg::S_DK_RD: begin
        cmd.rd_node_pos = 1'b1;
        state_nxt = imh_pkg::S_DK_WAIT;
      end
      imh_pkg::S_DK_WAIT: begin
        cmd.load_cur = 1'b1;
        state_nxt = imh_pkg::S_UP_RD;
      end
      imh_pkg::S_UP_RD: begin
        if (sts.at_root) state_nxt = imh_pkg::S_PLACE;
        else begin
          cmd.rd_parent = 1'b1;
          state_nxt = imh_pkg::S_UP_WAIT;
        end
      end
      imh_pkg::S_UP_WAIT: state_nxt = imh_pkg::S_UP_CMP;
      imh_pkg::S_UP_CMP: begin
        if (sts.parent_gt) begin
          cmd.move_up = 1'b1;
          state_nxt = imh_pkg::S_UP_RD;
        end else state_nxt = imh_pkg::S_PLACE;
      end
      imh_pkg::S_DEL_RD0: begin
        cmd.rd_root = 1'b1;
        state_nxt = imh_pkg::S_DEL_WAIT0;
      end
      imh_pkg::S_DEL_WAIT0: begin
        cmd.clr_root_tbl = 1'b1;
        cmd.cnt_dec = 1'b1;
        cmd.rd_last = 1'b1;
        state_nxt = sts.one_left ? imh_pkg::S_DONE : imh_pkg::S_DEL_LAST;
      end
      imh_pkg::S_DEL_LAST: begin
        cmd.load_last = 1'b1;
        cmd.init_root = 1'b1;
        state_nxt = imh_pkg::S_DN_RD;
      end
      imh_pkg::S_DN_RD: begin
        cmd.rd_children = 1'b1;
        state_nxt = imh_pkg::S_DN_WAIT;
      end
      imh_pkg::S_DN_WAIT: state_nxt = imh_pkg::S_DN_CMP;
      imh_pkg::S_DN_CMP: begin
        if (sts.child_lt) begin
          cmd.move_down = 1'b1;
          state_nxt = imh_pkg::S_DN_RD;
        end else state_nxt = imh_pkg::S_PLACE;
      end
      imh_pkg::S_LK_RD: begin
        cmd.rd_tbl = 1'b1;
        state_nxt = imh_pkg::S_LK_WAIT;
      end
      imh_pkg::S_LK_WAIT: begin
        cmd.set_tbl = 1'b1;
        state_nxt = imh_pkg::S_DONE;
      end
      imh_pkg::S_PLACE: begin
        cmd.place = 1'b1;
        cmd.set_pos = 1'b1;
        state_nxt = imh_pkg::S_DONE;
      end
      imh_pkg::S_DONE: begin
        cmd.done = 1'b1;
        state_nxt = imh_pkg::S_IDLE;
      end
      default: state_nxt = imh_pkg::S_IDLE;
    endcase
  end

endmodule

### hdl/imh_dpath.sv
// Datapath of the indexed min-heap: node memory, position table, count.
module imh_dpath #(
  parameter int KEY_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imh_pkg::cmd_t        cmd,
  output imh_pkg::sts_t        sts,
  input  logic [1:0]           in_op,
  input  logic [KEY_BITS-1:0]  in_key,
  input  logic [5:0]           in_cell_x,
  input  logic [5:0]           in_cell_y,
  input  logic [11:0]          in_heap_index,
  output logic                 out_strobe,
  output logic signed [12:0]   out_position,
  output logic [KEY_BITS-1:0]  out_root_key,
  output logic [5:0]           out_root_x,
  output logic [5:0]           out_root_y,
  output logic [12:0]          out_node_count,
  output logic [1:0]           out_status
);

  localparam int CAPACITY  = imh_pkg::CAPACITY;
  localparam int GRID_SIDE = imh_pkg::GRID_SIDE;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int GW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int TW = 2 * GW;
  localparam int NW = KEY_BITS + 12;
  localparam int PW = AW + 1;

  // Node memory: {key, x, y}
  logic [NW-1:0] node_mem [CAPACITY];
  logic [PW-1:0] tbl_mem [CELLS];

  // Transaction registers
  logic [1:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [5:0]          cx_r, cy_r;
  logic [11:0]         hidx_r;
  logic [CW-1:0]       count_r;
  logic [AW-1:0]       pos_r;
  logic [NW-1:0]       mov_r;     // node being moved
  logic [NW-1:0]       rda_r, rdb_r;
  logic [AW-1:0]       rda_addr, rdb_addr;
  logic [TW-1:0]       clr_idx_r;
  logic [PW-1:0]       tbl_rd_r;
  logic                rdb_ok_r, rda_ok_r;
  logic [AW:0]         chl_r;

  // Node fields
  function automatic logic [KEY_BITS-1:0] nkey(input logic [NW-1:0] n);
    return n[NW-1:12];
  endfunction

  logic in_grid;
  assign in_grid = ({26'd0, cx_r} < 32'(GRID_SIDE)) &&
                   ({26'd0, cy_r} < 32'(GRID_SIDE));

  function automatic logic [TW-1:0] tidx(input logic [5:0] x, input logic [5:0] y);
    return TW'(y[GW-1:0]) * TW'(GRID_SIDE) + TW'(x[GW-1:0]);
  endfunction

  function automatic logic node_in_grid(input logic [NW-1:0] n);
    return ({26'd0, n[11:6]} < 32'(GRID_SIDE)) && ({26'd0, n[5:0]} < 32'(GRID_SIDE));
  endfunction

  // Child and parent addresses
  logic [AW:0] left_w, right_w;
  logic [AW-1:0] parent_w;
  assign left_w   = {pos_r, 1'b1};
  assign right_w  = left_w + 1'b1;
  assign parent_w = AW'((pos_r - 1'b1) >> 1);

  // Read port addresses
  always_comb begin
    rda_addr = pos_r;
    rdb_addr = right_w[AW-1:0];
    if (cmd.rd_root) rda_addr = '0;
    else if (cmd.rd_last) rda_addr = AW'(count_r - 1'b1);
    else if (cmd.rd_parent) rda_addr = parent_w;
    else if (cmd.rd_children) rda_addr = left_w[AW-1:0];
  end

  logic rd_en;
  assign rd_en = cmd.rd_node_pos | cmd.rd_root | cmd.rd_last |
                 cmd.rd_parent | cmd.rd_children;

  // Memory reads, registered; data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en)           rda_r    <= node_mem[rda_addr];
    if (cmd.rd_children) rdb_r    <= node_mem[rdb_addr];
    if (cmd.rd_tbl)      tbl_rd_r <= tbl_mem[tidx(cx_r, cy_r)];
  end

  // Child bounds captured with the read
  always_ff @(posedge clk) begin
    if (cmd.rd_children) begin
      rda_ok_r <= (CW+1)'(left_w)  < (CW+1)'(count_r);
      rdb_ok_r <= (CW+1)'(right_w) < (CW+1)'(count_r);
      chl_r    <= left_w;
    end
  end

  // Sift-down choice: right on ties
  logic pick_r_w, lsm_w, rsm_w;
  assign lsm_w    = rda_ok_r && (nkey(rda_r) < nkey(mov_r));
  assign rsm_w    = rdb_ok_r && (nkey(rdb_r) < nkey(mov_r));
  assign pick_r_w = rdb_ok_r && !(nkey(rda_r) < nkey(rdb_r));

  logic [NW-1:0] wr_node;
  logic [AW-1:0] wr_addr, pick_addr;
  logic          wr_en;
  assign pick_addr = pick_r_w ? AW'(chl_r + 1'b1) : chl_r[AW-1:0];

  // Node and table writes
  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos_r;
    wr_node = mov_r;
    if (cmd.move_up) begin
      wr_en = 1'b1;
      wr_node = rda_r;
    end else if (cmd.move_down) begin
      wr_en = 1'b1;
      wr_node = pick_r_w ? rdb_r : rda_r;
    end else if (cmd.place) begin
      wr_en = 1'b1;
    end
  end

  logic          tw_en;
  logic [TW-1:0] tw_addr;
  logic [PW-1:0] tw_data;
  always_comb begin
    tw_en   = 1'b0;
    tw_addr = tidx(wr_node[11:6], wr_node[5:0]);
    tw_data = {1'b0, pos_r};
    if (cmd.clr_step) begin
      tw_en = 1'b1;
      tw_addr = clr_idx_r;
      tw_data = '1;
    end else if (cmd.clr_root_tbl) begin
      tw_en = node_in_grid(rda_r);
      tw_addr = tidx(rda_r[11:6], rda_r[5:0]);
      tw_data = '1;
    end else if (wr_en) begin
      tw_en = node_in_grid(wr_node);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) node_mem[wr_addr] <= wr_node;
    if (tw_en) tbl_mem[tw_addr] <= tw_data;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      clr_idx_r <= '0;
    end else begin
      if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.cnt_inc) count_r <= count_r + 1'b1;
      else if (cmd.cnt_dec) count_r <= count_r - 1'b1;
    end
  end

  // Moving node and position
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_op;
      key_r  <= in_key;
      cx_r   <= in_cell_x;
      cy_r   <= in_cell_y;
      hidx_r <= in_heap_index;
      pos_r  <= AW'(in_heap_index);
    end
    if (cmd.init_ins) begin
      pos_r <= AW'(count_r);
      mov_r <= {key_r, cx_r, cy_r};
    end
    if (cmd.load_cur)
      mov_r <= {((key_r < nkey(rda_r)) ? key_r : nkey(rda_r)), rda_r[11:0]};
    if (cmd.load_last) mov_r <= rda_r;
    if (cmd.init_root) pos_r <= '0;
    if (cmd.move_up) pos_r <= parent_w;
    if (cmd.move_down) pos_r <= pick_addr;
  end

  // Result registers
  logic signed [12:0] res_pos_r;
  logic [1:0]         res_st_r;
  logic               strobe_r;
  logic [NW-1:0]      root_r;
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      res_pos_r <= -13'sd1;
      res_st_r  <= imh_pkg::ST_OK;
    end
    if (cmd.set_status) res_st_r <= cmd.status;
    if (cmd.set_pos) res_pos_r <= 13'(pos_r);
    if (cmd.set_tbl)
      res_pos_r <= tbl_rd_r[PW-1] ? -13'sd1 : 13'(tbl_rd_r[AW-1:0]);
  end

  // Copy of the root node, follows every node write to position zero
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) root_r <= wr_node;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= cmd.done;
  end

  assign out_strobe     = strobe_r;
  assign out_position   = res_pos_r;
  assign out_root_key   = (count_r != '0) ? nkey(root_r) : '0;
  assign out_root_x     = (count_r != '0) ? root_r[11:6] : '0;
  assign out_root_y     = (count_r != '0) ? root_r[5:0] : '0;
  assign out_node_count = 13'(count_r);
  assign out_status     = res_st_r;

  // Status to the controller
  assign sts.clr_last  = (clr_idx_r == TW'(CELLS - 1));
  assign sts.op        = imh_pkg::op_t'(op_r);
  assign sts.in_grid   = in_grid;
  assign sts.full      = (count_r >= CW'(CAPACITY));
  assign sts.empty     = (count_r == '0);
  assign sts.idx_bad   = ({20'd0, hidx_r} >= 32'(count_r));
  assign sts.at_root   = (pos_r == '0);
  assign sts.parent_gt = nkey(rda_r) > nkey(mov_r);
  assign sts.child_lt  = lsm_w || rsm_w;
  assign sts.one_left  = (count_r == CW'(1));

endmodule

### hdl/indexed_min_heap_top.sv
// Top level of the indexed min-heap: controller plus datapath.
//
// Usage: drive in_* with start high while busy is low; the transaction is
// taken at that edge. One result follows per transaction, shown for one
// cycle with out_strobe high; the receiver cannot hold it off.
// Error answers skip the heap. Insert climbs level by level toward the
// root; decrease key first reads the node, then climbs like insert;
// delete reads the root and the last node, then sifts down level by
// level. Each level is one registered read of the node memory, a key
// compare and a write.
// One transaction is in flight at a time: busy stays high until the
// result strobe.
// Reset: count goes to zero and a clearing pass writes -1 into every
// entry of the position table, one a cycle, with busy high; node memory
// is not cleared.
// The root fields read zero while the heap is empty.
module indexed_min_heap_top #(
  parameter int KEY_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [5:0]          in_cell_x,
  input  logic [5:0]          in_cell_y,
  input  logic [11:0]         in_heap_index,
  output logic                out_strobe,
  output logic signed [12:0]  out_position,
  output logic [KEY_BITS-1:0] out_root_key,
  output logic [5:0]          out_root_x,
  output logic [5:0]          out_root_y,
  output logic [12:0]         out_node_count,
  output logic [1:0]          out_status
);

  imh_pkg::cmd_t cmd;
  imh_pkg::sts_t sts;

  // Sequencer
  imh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Storage and compare
  imh_dpath #(
    .KEY_BITS  (KEY_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_heap_index  (in_heap_index),
    .out_strobe     (out_strobe),
    .out_position   (out_position),
    .out_root_key   (out_root_key),
    .out_root_x     (out_root_x),
    .out_root_y     (out_root_y),
    .out_node_count (out_node_count),
    .out_status     (out_status)
  );

endmodule

### verif/indexed_min_heap_checker.sv
// Checker for the indexed min-heap: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps

module indexed_min_heap_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_key,
  input  logic [5:0]         in_cell_x,
  input  logic [5:0]         in_cell_y,
  input  logic [11:0]        in_heap_index,
  input  logic               out_strobe,
  input  logic signed [12:0] out_position,
  input  logic [31:0]        out_root_key,
  input  logic [5:0]         out_root_x,
  input  logic [5:0]         out_root_y,
  input  logic [12:0]        out_node_count,
  input  logic [1:0]         out_status,
  output int                 errors,
  output int                 pending
);

  localparam int HEAP_CAP = 4096;
  localparam int CELLS    = 4096;

  typedef struct {
    logic signed [12:0]    position;
    logic [31:0]           root_key;
    logic [5:0]            root_x;
    logic [5:0]            root_y;
    logic [12:0]           node_count;
    imh_pkg::status_t      status;
  } heap_result_t;

  // Shadow copy of the heap, the cell table and the node count
  logic [31:0] node_key [HEAP_CAP];
  logic [5:0]  node_x   [HEAP_CAP];
  logic [5:0]  node_y   [HEAP_CAP];
  int          cell_pos [CELLS];
  int          nodes;

  heap_result_t awaited_results[$];

  function automatic int cell_of(logic [5:0] x, logic [5:0] y);
    return int'(y) * 64 + int'(x);
  endfunction

  // Place a node at p and carry it up past strictly larger parents
  function automatic int float_up(int p, logic [31:0] k, logic [5:0] x, logic [5:0] y);
    int up;
    while (p != 0) begin
      up = (p - 1) / 2;
      if (!(node_key[up] > k)) break;
      node_key[p] = node_key[up];
      node_x[p]   = node_x[up];
      node_y[p]   = node_y[up];
      cell_pos[cell_of(node_x[p], node_y[p])] = p;
      p = up;
    end
    node_key[p] = k;
    node_x[p]   = x;
    node_y[p]   = y;
    cell_pos[cell_of(x, y)] = p;
    return p;
  endfunction

  // Remove the root, sink the last node; returns its final position or -1
  function automatic int pop_root();
    logic [31:0] lk;
    logic [5:0]  lx, ly;
    int at, l, r, pick;
    bit lsm, rsm;
    cell_pos[cell_of(node_x[0], node_y[0])] = -1;
    nodes--;
    if (nodes == 0) return -1;
    lk = node_key[nodes];
    lx = node_x[nodes];
    ly = node_y[nodes];
    at = 0;
    forever begin
      l = 2 * at + 1;
      r = l + 1;
      lsm = l < nodes && node_key[l] < lk;
      rsm = r < nodes && node_key[r] < lk;
      if (!lsm && !rsm) break;
      // ties between the children go right
      pick = (r >= nodes || node_key[l] < node_key[r]) ? l : r;
      node_key[at] = node_key[pick];
      node_x[at]   = node_x[pick];
      node_y[at]   = node_y[pick];
      cell_pos[cell_of(node_x[at], node_y[at])] = at;
      at = pick;
    end
    node_key[at] = lk;
    node_x[at]   = lx;
    node_y[at]   = ly;
    cell_pos[cell_of(lx, ly)] = at;
    return at;
  endfunction

  function automatic heap_result_t heap_apply(imh_pkg::op_t op, logic [31:0] k,
                                              logic [5:0] x, logic [5:0] y,
                                              logic [11:0] hidx);
    heap_result_t res;
    logic [31:0] nk;
    int pos;
    pos = -1;
    res.status = imh_pkg::ST_OK;
    case (op)
      imh_pkg::OP_INSERT: begin
        if (nodes >= HEAP_CAP) begin
          res.status = imh_pkg::ST_FULL;
        end else begin
          nodes++;
          pos = float_up(nodes - 1, k, x, y);
        end
      end
      imh_pkg::OP_DECKEY: begin
        if (int'(hidx) >= nodes) begin
          res.status = imh_pkg::ST_RANGE;
        end else begin
          nk = (k < node_key[hidx]) ? k : node_key[hidx];
          pos = float_up(int'(hidx), nk, node_x[hidx], node_y[hidx]);
        end
      end
      imh_pkg::OP_DELETE: begin
        if (nodes == 0) res.status = imh_pkg::ST_EMPTY;
        else pos = pop_root();
      end
      default: pos = cell_pos[cell_of(x, y)];
    endcase
    res.position   = 13'(pos);
    res.root_key   = (nodes > 0) ? node_key[0] : '0;
    res.root_x     = (nodes > 0) ? node_x[0] : '0;
    res.root_y     = (nodes > 0) ? node_y[0] : '0;
    res.node_count = 13'(nodes);
    return res;
  endfunction

  // Predict on each accepted transaction, compare on each result strobe
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      nodes = 0;
      errors = 0;
      for (int i = 0; i < CELLS; i++) cell_pos[i] = -1;
      awaited_results.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            errors++;
          end
          if (out_root_key !== want.root_key) begin
            $error("root_key: expected %0h, got %0h", want.root_key, out_root_key);
            errors++;
          end
          if (out_root_x !== want.root_x) begin
            $error("root_x: expected %0d, got %0d", want.root_x, out_root_x);
            errors++;
          end
          if (out_root_y !== want.root_y) begin
            $error("root_y: expected %0d, got %0d", want.root_y, out_root_y);
            errors++;
          end
          if (out_node_count !== want.node_count) begin
            $error("node_count: expected %0d, got %0d", want.node_count, out_node_count);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
        end
      end
      if (start && !busy)
        awaited_results.push_back(heap_apply(imh_pkg::op_t'(in_op), in_key, in_cell_x,
                                             in_cell_y, in_heap_index));
    end
    pending = awaited_results.size();
  end

endmodule

### verif/indexed_min_heap_top_tb.sv
// Testbench top for the indexed min-heap: stimulus, verdict and run limit.
`timescale 1ns / 100ps

module indexed_min_heap_top_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_op = imh_pkg::OP_LOOKUP;
  logic [31:0]        in_key = '0;
  logic [5:0]         in_cell_x = '0;
  logic [5:0]         in_cell_y = '0;
  logic [11:0]        in_heap_index = '0;
  logic               out_strobe;
  logic signed [12:0] out_position;
  logic [31:0]        out_root_key;
  logic [5:0]         out_root_x;
  logic [5:0]         out_root_y;
  logic [12:0]        out_node_count;
  logic [1:0]         out_status;
  int                 errors;
  int                 pending;

  // Stimulus-side view of the fill level, used to aim decrease-key indexes
  int held;
  int op_sent[4];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_min_heap_top dut (.*);

  indexed_min_heap_checker checker_i (.*);

  // Present one transaction after a random gap and hold it until taken
  task automatic issue(imh_pkg::op_t op, logic [31:0] k, logic [5:0] x, logic [5:0] y,
                       logic [11:0] hidx);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_key        <= k;
    in_cell_x     <= x;
    in_cell_y     <= y;
    in_heap_index <= hidx;
    do @(negedge clk); while (busy);
    @(posedge clk);
    op_sent[op]++;
    if (op == imh_pkg::OP_INSERT && held < 4096) held++;
    if (op == imh_pkg::OP_DELETE && held > 0) held--;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1, 2: return 32'($urandom_range(0, 15));
      3:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_index();
    if (held > 0 && $urandom_range(0, 9) != 0) return 12'($urandom_range(0, held - 1));
    return 12'($urandom);
  endfunction

  task automatic random_item();
    int w;
    w = $urandom_range(0, 99);
    if (held < 6) w = w / 2;
    if (w < 40)
      issue(imh_pkg::OP_INSERT, pick_key(), 6'($urandom), 6'($urandom), 12'($urandom));
    else if (w < 60)
      issue(imh_pkg::OP_DECKEY, pick_key(), 6'($urandom), 6'($urandom), pick_index());
    else if (w < 85)
      issue(imh_pkg::OP_DELETE, $urandom, 6'($urandom), 6'($urandom), 12'($urandom));
    else
      issue(imh_pkg::OP_LOOKUP, $urandom, 6'($urandom), 6'($urandom), 12'($urandom));
  endtask

  initial begin
    held = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty heap, extremes, ties, duplicate cell, odd decrease keys
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_LOOKUP, '0, 6'd63, 6'd63, '0);
    issue(imh_pkg::OP_DECKEY, '0, '0, '0, '0);
    issue(imh_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63, 6'd63, 12'hFFF);
    issue(imh_pkg::OP_INSERT, 32'd5, 6'd0, 6'd0, '0);
    issue(imh_pkg::OP_INSERT, 32'd5, 6'd1, 6'd0, '0);
    issue(imh_pkg::OP_INSERT, 32'd5, 6'd2, 6'd0, '0);
    issue(imh_pkg::OP_INSERT, 32'd0, 6'd0, 6'd63, '0);
    issue(imh_pkg::OP_INSERT, 32'd7, 6'd0, 6'd0, '0);
    issue(imh_pkg::OP_LOOKUP, '0, 6'd0, 6'd0, '0);
    issue(imh_pkg::OP_DECKEY, 32'hFFFF_FFFF, '0, '0, 12'd2);
    issue(imh_pkg::OP_DECKEY, 32'd0, '0, '0, 12'd5);
    issue(imh_pkg::OP_DECKEY, 32'd0, '0, '0, 12'hFFF);
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_LOOKUP, '0, 6'd63, 6'd63, '0);
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_LOOKUP, '0, 6'd2, 6'd0, '0);

    for (int i = 0; i < 700; i++) random_item();

    // Drain whatever is left, then one delete on the empty heap
    while (held > 0) issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    issue(imh_pkg::OP_DELETE, '0, '0, '0, '0);
    start <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);

    $display("Covered %0d inserts, %0d decrease keys, %0d deletes, %0d lookups,",
             op_sent[imh_pkg::OP_INSERT], op_sent[imh_pkg::OP_DECKEY],
             op_sent[imh_pkg::OP_DELETE], op_sent[imh_pkg::OP_LOOKUP]);
    $display("ending with a full drain of the heap; %0d mismatches.", errors);
    if (errors == 0)
      $display("indexed_min_heap_top test passed");
    else
      $display("indexed_min_heap_top test failed");
    $finish;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("indexed_min_heap_top test failed");
    $finish;
  end

endmodule
